/* hdl/oct_pkg.sv */
// ----------------------------------------------------------------------------
// oct_pkg: shared types, codes and tables of the octree edge enumerator
// Frame codes, the child tables of the cell, face and edge visits, and the
// edge total used to flag the final edge of a walk.
// ----------------------------------------------------------------------------
package oct_pkg;

   localparam logic [1:0] KIND_CELL = 2'd0;
   localparam logic [1:0] KIND_FACE = 2'd1;
   localparam logic [1:0] KIND_EDGE = 2'd2;
   localparam logic [1:0] AX_Z = 2'd0;
   localparam logic [1:0] AX_Y = 2'd1;
   localparam logic [1:0] AX_X = 2'd2;

   localparam int CELL_W = 16;
   localparam int INFO_W = 9;   // kind 1:0, axis 3:2, children opened 8:4
   localparam int FRAME_W = 4 * CELL_W;

   // one child visit: slot = source cell * 8 + octant
   typedef struct packed {
      logic [1:0]      kind;
      logic [1:0]      axis;
      logic [3:0][4:0] slot;
   } desc_type;

   // child visit as produced for the controller
   typedef struct packed {
      logic               has;
      logic [1:0]         kind;
      logic [1:0]         axis;
      logic [FRAME_W-1:0] cells;
   } child_type;

   function automatic desc_type mk(logic [1:0] k, logic [1:0] a, logic [4:0] s0,
                                   logic [4:0] s1, logic [4:0] s2, logic [4:0] s3);
      desc_type d;
      d.kind = k;
      d.axis = a;
      d.slot[0] = s0;
      d.slot[1] = s1;
      d.slot[2] = s2;
      d.slot[3] = s3;
      return d;
   endfunction

   localparam desc_type CELL_KIDS [26] = '{
      mk(KIND_CELL, AX_Z, 0, 0, 0, 0), mk(KIND_CELL, AX_Z, 1, 0, 0, 0),
      mk(KIND_CELL, AX_Z, 2, 0, 0, 0), mk(KIND_CELL, AX_Z, 3, 0, 0, 0),
      mk(KIND_CELL, AX_Z, 4, 0, 0, 0), mk(KIND_CELL, AX_Z, 5, 0, 0, 0),
      mk(KIND_CELL, AX_Z, 6, 0, 0, 0), mk(KIND_CELL, AX_Z, 7, 0, 0, 0),
      mk(KIND_FACE, AX_Y, 0, 2, 0, 0), mk(KIND_FACE, AX_Y, 1, 3, 0, 0),
      mk(KIND_FACE, AX_Y, 4, 6, 0, 0), mk(KIND_FACE, AX_Y, 5, 7, 0, 0),
      mk(KIND_FACE, AX_X, 0, 4, 0, 0), mk(KIND_FACE, AX_X, 1, 5, 0, 0),
      mk(KIND_FACE, AX_X, 2, 6, 0, 0), mk(KIND_FACE, AX_X, 3, 7, 0, 0),
      mk(KIND_FACE, AX_Z, 0, 1, 0, 0), mk(KIND_FACE, AX_Z, 2, 3, 0, 0),
      mk(KIND_FACE, AX_Z, 4, 5, 0, 0), mk(KIND_FACE, AX_Z, 6, 7, 0, 0),
      mk(KIND_EDGE, AX_Y, 0, 4, 1, 5), mk(KIND_EDGE, AX_Y, 2, 6, 3, 7),
      mk(KIND_EDGE, AX_X, 0, 1, 2, 3), mk(KIND_EDGE, AX_X, 4, 5, 6, 7),
      mk(KIND_EDGE, AX_Z, 0, 4, 2, 6), mk(KIND_EDGE, AX_Z, 1, 5, 3, 7)
   };

   localparam desc_type FACE_KIDS [3][8] = '{
      '{mk(KIND_FACE, AX_Z, 1, 8, 0, 0), mk(KIND_FACE, AX_Z, 3, 10, 0, 0),
        mk(KIND_FACE, AX_Z, 5, 12, 0, 0), mk(KIND_FACE, AX_Z, 7, 14, 0, 0),
        mk(KIND_EDGE, AX_X, 1, 8, 3, 10), mk(KIND_EDGE, AX_X, 5, 12, 7, 14),
        mk(KIND_EDGE, AX_Y, 1, 5, 8, 12), mk(KIND_EDGE, AX_Y, 3, 7, 10, 14)},
      '{mk(KIND_FACE, AX_Y, 2, 8, 0, 0), mk(KIND_FACE, AX_Y, 3, 9, 0, 0),
        mk(KIND_FACE, AX_Y, 6, 12, 0, 0), mk(KIND_FACE, AX_Y, 7, 13, 0, 0),
        mk(KIND_EDGE, AX_X, 2, 3, 8, 9), mk(KIND_EDGE, AX_X, 6, 7, 12, 13),
        mk(KIND_EDGE, AX_Z, 2, 6, 8, 12), mk(KIND_EDGE, AX_Z, 3, 7, 9, 13)},
      '{mk(KIND_FACE, AX_X, 4, 8, 0, 0), mk(KIND_FACE, AX_X, 5, 9, 0, 0),
        mk(KIND_FACE, AX_X, 6, 10, 0, 0), mk(KIND_FACE, AX_X, 7, 11, 0, 0),
        mk(KIND_EDGE, AX_Y, 4, 8, 5, 9), mk(KIND_EDGE, AX_Y, 6, 10, 7, 11),
        mk(KIND_EDGE, AX_Z, 4, 8, 6, 10), mk(KIND_EDGE, AX_Z, 5, 9, 7, 11)}
   };

   localparam desc_type EDGE_KIDS [3][2] = '{
      '{mk(KIND_EDGE, AX_Z, 6, 10, 20, 24), mk(KIND_EDGE, AX_Z, 7, 11, 21, 25)},
      '{mk(KIND_EDGE, AX_Y, 5, 9, 20, 24), mk(KIND_EDGE, AX_Y, 7, 11, 22, 26)},
      '{mk(KIND_EDGE, AX_X, 3, 10, 17, 24), mk(KIND_EDGE, AX_X, 7, 14, 21, 28)}
   };

   // number of edges a whole walk reports down to a given depth
   function automatic longint unsigned edge_total(int lim);
      longint unsigned e;
      longint unsigned f;
      longint unsigned c;
      longint unsigned nc;
      longint unsigned nf;
      e = 1;
      f = 0;
      c = 0;
      for (int i = 0; i < lim; i++) begin
         nc = 8 * c + 12 * f + 6 * e;
         nf = 4 * f + 4 * e;
         e = 2 * e + 1;
         f = nf;
         c = nc;
      end
      return c;
   endfunction

endpackage

/* hdl/oct_if.sv */
// ----------------------------------------------------------------------------
// oct_req_if / oct_rsp_if: valid/ready channels of the edge enumerator
// Request carries the restart flag, response carries one edge.
// ----------------------------------------------------------------------------
interface oct_req_if;
   logic valid;
   logic ready;
   logic restart;
   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface oct_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] cell_a;
   logic [15:0] cell_b;
   logic [15:0] cell_c;
   logic [15:0] cell_d;
   logic [1:0]  edge_axis;
   logic [16:0] edge_number;
   logic        final_edge;
   modport source (output valid, output cell_a, output cell_b, output cell_c,
                   output cell_d, output edge_axis, output edge_number,
                   output final_edge, input ready);
   modport sink (input valid, input cell_a, input cell_b, input cell_c,
                 input cell_d, input edge_axis, input edge_number,
                 input final_edge, output ready);
endinterface

/* hdl/oct_ram.sv */
// ----------------------------------------------------------------------------
// oct_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module oct_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write, then register the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* hdl/oct_child_gen.sv */
// ----------------------------------------------------------------------------
// oct_child_gen: next child visit of a frame
// Looks up the child of the frame's kind and progress and builds its ids.
// ----------------------------------------------------------------------------
module oct_child_gen
   import oct_pkg::*;
(
   input  logic               open_ok,
   input  logic [INFO_W-1:0]  info,
   input  logic [FRAME_W-1:0] cells,
   output child_type          child
);
   logic [1:0] kind;
   logic [1:0] ax;
   logic [4:0] prog;
   logic       found;
   desc_type   d;
   logic [CELL_W-1:0] p;

   assign kind = info[1:0];
   assign ax   = (info[3:2] == 2'd3) ? AX_Z : info[3:2];
   assign prog = info[8:4];

   // pick the child descriptor
   always_comb begin
      found = 1'b0;
      d = CELL_KIDS[0];
      if (open_ok) begin
         if (kind == KIND_CELL && prog < 5'd26) begin
            found = 1'b1;
            d = CELL_KIDS[prog];
         end else if (kind == KIND_FACE && prog < 5'd8) begin
            found = 1'b1;
            d = FACE_KIDS[ax][prog[2:0]];
         end else if (kind == KIND_EDGE && prog < 5'd2) begin
            found = 1'b1;
            d = EDGE_KIDS[ax][prog[0]];
         end
      end
   end

   // build the four child ids
   always_comb begin
      child.has  = found;
      child.kind = d.kind;
      child.axis = d.axis;
      child.cells = '0;
      p = '0;
      for (int s = 0; s < 4; s++) begin
         p = cells[d.slot[s][4:3]*CELL_W +: CELL_W];
         child.cells[s*CELL_W +: CELL_W] =
            {p[CELL_W-4:0], 3'b000} + {13'd0, d.slot[s][2:0]} + 16'd1;
      end
   end
endmodule

/* hdl/octree_dual_edge_enumerator.sv */
// ----------------------------------------------------------------------------
// octree_dual_edge_enumerator: depth-first minimal edge walk of an octree
// Cell, face and edge visits of a complete octree, one edge per request.
// ----------------------------------------------------------------------------
// Each advance request returns the next edge of the walk; a restart request,
// a write of tree_depth, or an advance after the last edge returns nothing.
// The frame stack lives in two RAMs (cell ids, frame info), one entry per
// level. Each visited frame is read (S_READ) and then evaluated (S_EVAL), and
// a push adds S_PUSH for the second info write; an edge child goes on from
// S_PUSH to S_OUT, which returns the edge. At depth five the longest advances
// come when the walk climbs out of a finished subtree and descends to a cell
// just above the leaves, which first visits its 20 childless cells and faces.
// A restart or register write rewrites the root frame in S_INIT.
module octree_dual_edge_enumerator
   import oct_pkg::*;
#(
   parameter int DEPTH_MAX = 5
) (
   input  logic        clock,
   input  logic        reset,
   oct_req_if.sink     req_chan,
   oct_rsp_if.source   rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int LEVELS = DEPTH_MAX + 1;
   localparam int LVL_W = $clog2(LEVELS);
   localparam int TOT_W = $clog2(edge_total(DEPTH_MAX) + 1);
   localparam int CNT_W = (TOT_W > 17) ? TOT_W : 17;
   localparam logic [3:0] DMAX = 4'(DEPTH_MAX);

   typedef enum logic [5:0] {
      S_INIT = 6'b000001,
      S_IDLE = 6'b000010,
      S_READ = 6'b000100,
      S_EVAL = 6'b001000,
      S_PUSH = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0]       depth_ff, depth_in;
   logic [LVL_W-1:0] stack_ff, stack_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             fin_ff, fin_in;
   logic [1:0]       kind_ff, kind_in;
   logic [1:0]       axis_ff, axis_in;
   logic [FRAME_W-1:0] cells_ff, cells_in;
   logic             last_ff, last_in;
   logic [16:0]      num_ff, num_in;

   logic [CNT_W-1:0] tot_tab [LEVELS];
   logic [3:0]       lim;
   logic [LVL_W-1:0] lim_lvl;
   logic             open_ok;
   logic             cfg_wr;
   logic             req_acc;

   logic               cram_we, iram_we;
   logic [LVL_W-1:0]   cram_wa, iram_wa;
   logic [FRAME_W-1:0] cram_wd, cram_rd;
   logic [INFO_W-1:0]  iram_wd, iram_rd;
   child_type          child;

   // edge totals per depth, worked out at elaboration
   for (genvar g = 0; g < LEVELS; g++) begin : g_tot
      assign tot_tab[g] = CNT_W'(edge_total(g));
   end

   // register port
   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_pready && !csr_paddr[2];
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {29'd0, depth_ff};

   // clamp the depth limit
   assign lim = ({1'b0, depth_ff} > DMAX) ? DMAX : {1'b0, depth_ff};
   assign lim_lvl = lim[LVL_W-1:0];
   assign open_ok = 4'(stack_ff) < lim;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_acc = req_chan.valid && req_chan.ready;

   oct_ram #(.WIDTH(FRAME_W), .DEPTH(LEVELS)) u_cell_ram (
      .clock   (clock),
      .wr_en   (cram_we),
      .wr_addr (cram_wa),
      .wr_data (cram_wd),
      .rd_addr (stack_ff),
      .rd_data (cram_rd)
   );

   oct_ram #(.WIDTH(INFO_W), .DEPTH(LEVELS)) u_info_ram (
      .clock   (clock),
      .wr_en   (iram_we),
      .wr_addr (iram_wa),
      .wr_data (iram_wd),
      .rd_addr (stack_ff),
      .rd_data (iram_rd)
   );

   oct_child_gen u_child (
      .open_ok (open_ok),
      .info    (iram_rd),
      .cells   (cram_rd),
      .child   (child)
   );

   // walk sequencer
   always_comb begin
      state_in = state_ff;
      depth_in = depth_ff;
      stack_in = stack_ff;
      count_in = count_ff;
      fin_in   = fin_ff;
      kind_in  = kind_ff;
      axis_in  = axis_ff;
      cells_in = cells_ff;
      last_in  = last_ff;
      num_in   = num_ff;
      cram_we  = 1'b0;
      cram_wa  = '0;
      cram_wd  = '0;
      iram_we  = 1'b0;
      iram_wa  = '0;
      iram_wd  = '0;
      unique case (state_ff)
         S_INIT: begin
            cram_we  = 1'b1;
            iram_we  = 1'b1;
            stack_in = '0;
            count_in = '0;
            fin_in   = 1'b0;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_acc) begin
               if (req_chan.restart) begin
                  state_in = S_INIT;
               end else if (!fin_ff) begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (!child.has) begin
               if (stack_ff == '0) begin
                  fin_in   = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  stack_in = stack_ff - 1'b1;
                  state_in = S_READ;
               end
            end else begin
               // advance the frame and store the child's cells
               iram_we  = 1'b1;
               iram_wa  = stack_ff;
               iram_wd  = {iram_rd[8:4] + 5'd1, iram_rd[3:0]};
               cram_we  = 1'b1;
               cram_wa  = stack_ff + 1'b1;
               cram_wd  = child.cells;
               kind_in  = child.kind;
               axis_in  = child.axis;
               cells_in = child.cells;
               if (child.kind == KIND_EDGE) begin
                  num_in   = count_ff[16:0];
                  last_in  = (count_ff + 1'b1) == tot_tab[lim_lvl];
                  count_in = count_ff + 1'b1;
               end
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            iram_we  = 1'b1;
            iram_wa  = stack_ff + 1'b1;
            iram_wd  = {5'd0, axis_ff, kind_ff};
            stack_in = stack_ff + 1'b1;
            state_in = (kind_ff == KIND_EDGE) ? S_OUT : S_READ;
         end
         S_OUT: begin
            if (rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
      // a register write restarts the walk
      if (cfg_wr) begin
         depth_in = csr_pwdata[2:0];
         state_in = S_INIT;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         depth_ff <= 3'd5;
         stack_ff <= '0;
         count_ff <= '0;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         depth_ff <= depth_in;
         stack_ff <= stack_in;
         count_ff <= count_in;
         fin_ff   <= fin_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      axis_ff  <= axis_in;
      cells_ff <= cells_in;
      last_ff  <= last_in;
      num_ff   <= num_in;
   end

   assign rsp_chan.valid       = (state_ff == S_OUT);
   assign rsp_chan.cell_a      = cells_ff[0*CELL_W +: CELL_W];
   assign rsp_chan.cell_b      = cells_ff[1*CELL_W +: CELL_W];
   assign rsp_chan.cell_c      = cells_ff[2*CELL_W +: CELL_W];
   assign rsp_chan.cell_d      = cells_ff[3*CELL_W +: CELL_W];
   assign rsp_chan.edge_axis   = axis_ff;
   assign rsp_chan.edge_number = num_ff;
   assign rsp_chan.final_edge  = last_ff;

`ifndef SYNTHESIS
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      4'(stack_ff) <= DMAX)
      else $error("frame stack above depth limit");
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_chan.restart) |=> (state_ff == S_INIT))
      else $error("restart did not rewrite root frame");
   a_push: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUSH && !cfg_wr) |=> (stack_ff == $past(stack_ff) + 1'b1))
      else $error("push did not advance stack");
`endif
endmodule
